// File: rtl/owbs_pkg.sv
// Shared constants for the overlap-weighted box smoother.
// Field widths, register indexes and reset values, divider sizes.
// No dependencies.
package owbs_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BOX_W      = 4 * FIELD_W;
    localparam int WINDOW_DEF = 8;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_NEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_NEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_FAR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FAR  = 2'd3;

    localparam logic [CFG_W-1:0] RST_KNEE_NEAR  = 16'd4096;
    localparam logic [CFG_W-1:0] RST_LEVEL_NEAR = 16'd8192;
    localparam logic [CFG_W-1:0] RST_KNEE_FAR   = 16'd16384;
    localparam logic [CFG_W-1:0] RST_LEVEL_FAR  = 16'd1638;

    // Shared divider: quotient always below 2^DIV_Q_W
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W - 1;

endpackage

// File: rtl/owbs_if.sv
// Channel interfaces of the box smoother: input box, output box, register writes.
// Depends on owbs_pkg.
interface owbs_in_if import owbs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] box_x;
    logic signed [FIELD_W-1:0] box_y;
    logic        [FIELD_W-1:0] box_width;
    logic        [FIELD_W-1:0] box_height;
    modport source (output valid, box_x, box_y, box_width, box_height, input ready);
    modport sink (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface

interface owbs_out_if import owbs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic        [FIELD_W-1:0] out_width;
    logic        [FIELD_W-1:0] out_height;
    logic                      smoothed;
    modport source (output valid, out_x, out_y, out_width, out_height, smoothed, input ready);
    modport sink (input valid, out_x, out_y, out_width, out_height, smoothed, output ready);
endinterface

interface owbs_cfg_if import owbs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/overlap_weighted_box_smoother.sv
// Top level of the overlap-weighted box smoother: sequencer, datapath, registers.
// Depends on owbs_pkg, owbs_if, owbs_ram, owbs_div.
//
//   port     dir  kind          payload
//   i_box    in   valid/ready   box_x, box_y, box_width, box_height
//   o_res    out  valid/ready   out_x, out_y, out_width, out_height, smoothed
//   i_cfg    in   valid/ready   index, data (always ready)
//
// While the window fills, a box taken in S_IDLE goes straight to S_OUT and is
// offered once the output register is free; no new box is taken until S_IDLE returns.
// A smoothed box keeps the input closed while every stored box, the current box
// and the four final averages are worked through. Most of that time goes to the
// single divider, which takes 17 steps per division. History lives in one RAM
// used as a ring buffer.
// Reset is synchronous; after reset the window is empty.
// A finished result waits in the output register; the next box is taken
// meanwhile and stalls only when its own result finds that register full.
module overlap_weighted_box_smoother import owbs_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    owbs_in_if.sink     i_box,
    owbs_out_if.source  o_res,
    owbs_cfg_if.sink    i_cfg
);

    localparam int DEPTH = WINDOW - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(WINDOW);
    localparam int WS_W  = FIELD_W + IW;
    localparam int ACC_W = 2 * FIELD_W + 2 + IW;
    localparam logic [IW-1:0] LAST_IDX  = IW'(WINDOW - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CA    = 5'd1;
    localparam logic [4:0] S_D0SQ  = 5'd2;
    localparam logic [4:0] S_RD    = 5'd3;
    localparam logic [4:0] S_GEO   = 5'd4;
    localparam logic [4:0] S_OV    = 5'd5;
    localparam logic [4:0] S_AB    = 5'd6;
    localparam logic [4:0] S_TERM  = 5'd7;
    localparam logic [4:0] S_TDIV  = 5'd8;
    localparam logic [4:0] S_TWAIT = 5'd9;
    localparam logic [4:0] S_T     = 5'd10;
    localparam logic [4:0] S_CV    = 5'd11;
    localparam logic [4:0] S_QNUM  = 5'd12;
    localparam logic [4:0] S_CDIV  = 5'd13;
    localparam logic [4:0] S_CWAIT = 5'd14;
    localparam logic [4:0] S_ACC   = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_FDIV  = 5'd17;
    localparam logic [4:0] S_FWAIT = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    // Position scale table, Q2.14
    logic [15:0] w_scale [WINDOW];
    for (genvar g = 0; g < WINDOW; g++) begin : g_scale
        localparam int REM = WINDOW - g;
        localparam logic [15:0] SC = 16'(16384 + ((((REM - 1) << 14) + REM / 2) / REM));
        assign w_scale[g] = SC;
    end

    // Configuration registers
    logic [CFG_W-1:0] r_knee_near, r_level_near, r_knee_far, r_level_far;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knee_near  <= RST_KNEE_NEAR;
            r_level_near <= RST_LEVEL_NEAR;
            r_knee_far   <= RST_KNEE_FAR;
            r_level_far  <= RST_LEVEL_FAR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KNEE_NEAR:  r_knee_near  <= i_cfg.data;
                CFG_LEVEL_NEAR: r_level_near <= i_cfg.data;
                CFG_KNEE_FAR:   r_knee_far   <= i_cfg.data;
                CFG_LEVEL_FAR:  r_level_far  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Control and datapath registers
    logic [4:0]              r_state;
    logic [IW-1:0]           r_fill;
    logic [AW-1:0]           r_head;
    logic [IW-1:0]           r_idx;
    logic [1:0]              r_j;
    logic                    r_ovalid;
    logic signed [16:0]      r_cur [4];
    logic signed [16:0]      r_box [4];
    logic [15:0]             r_iw, r_ih;
    logic [31:0]             r_ov, r_ab, r_acur, r_d0sq, r_tt;
    logic [14:0]             r_term;
    logic [15:0]             r_t, r_k, r_base, r_w;
    logic                    r_neg;
    logic [DIV_NUM_W-1:0]    r_num;
    logic [DIV_DEN_W-1:0]    r_den;
    logic [WS_W-1:0]         r_wsum;
    logic signed [ACC_W-1:0] r_acc [4];
    logic [15:0]             r_res [4];
    logic                    r_smooth;
    logic [15:0]             r_out [4];
    logic                    r_osm;

    // RAM and divider hookup
    logic [BOX_W-1:0] w_rdata;
    logic [AW:0]      w_rsum;
    logic [AW-1:0]    w_raddr, w_waddr;
    logic             w_we, w_out_free, w_take;
    logic             w_div_start, w_div_done;
    logic [DIV_Q_W-1:0] w_q;

    assign w_take     = i_box.valid && i_box.ready;
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_rsum     = (AW+1)'(r_head) + (AW+1)'(r_idx);
    assign w_raddr    = (w_rsum >= (AW+1)'(DEPTH)) ? AW'(w_rsum - (AW+1)'(DEPTH)) : AW'(w_rsum);
    assign w_waddr    = (r_fill != LAST_IDX) ? AW'(r_fill) : r_head;
    assign w_we       = (r_state == S_OUT) && w_out_free;
    assign w_div_start = (r_state == S_TDIV) || (r_state == S_CDIV) || (r_state == S_FDIV);

    owbs_ram #(.WIDTH(BOX_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_cur[0][15:0], r_cur[1][15:0], r_cur[2][15:0], r_cur[3][15:0]}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    owbs_div #(.DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_q)
    );

    // Intersection of the stored box with the current one
    logic signed [16:0] w_bf [4];
    logic signed [17:0] w_l, w_tp, w_r, w_bt, w_ar, w_cr, w_ab, w_cb;
    logic [15:0]        w_iw, w_ih;

    assign w_bf[0] = {w_rdata[63], w_rdata[63:48]};
    assign w_bf[1] = {w_rdata[47], w_rdata[47:32]};
    assign w_bf[2] = {1'b0, w_rdata[31:16]};
    assign w_bf[3] = {1'b0, w_rdata[15:0]};
    assign w_l  = (w_bf[0] > r_cur[0]) ? 18'(w_bf[0]) : 18'(r_cur[0]);
    assign w_tp = (w_bf[1] > r_cur[1]) ? 18'(w_bf[1]) : 18'(r_cur[1]);
    assign w_ar = 18'(w_bf[0]) + 18'(w_bf[2]);
    assign w_cr = 18'(r_cur[0]) + 18'(r_cur[2]);
    assign w_ab = 18'(w_bf[1]) + 18'(w_bf[3]);
    assign w_cb = 18'(r_cur[1]) + 18'(r_cur[3]);
    assign w_r  = (w_ar < w_cr) ? w_ar : w_cr;
    assign w_bt = (w_ab < w_cb) ? w_ab : w_cb;
    assign w_iw = (w_r > w_l) ? 16'(w_r - w_l) : 16'd0;
    assign w_ih = (w_bt > w_tp) ? 16'(w_bt - w_tp) : 16'd0;

    // Term scaling and weight curve
    logic [31:0]        w_min, w_tprod, w_lprod;
    logic [47:0]        w_qprod;
    logic               w_qneg, w_lneg;
    logic [15:0]        w_qmag, w_lmag, w_lden;
    logic [17:0]        w_wv;
    logic signed [33:0] w_wprod;
    logic [ACC_W-1:0]   w_amag;

    assign w_min   = (r_ab < r_acur) ? r_ab : r_acur;
    assign w_tprod = 32'(r_term) * 32'(w_scale[r_idx]) + 32'd8192;
    assign w_qneg  = r_level_near < ONE_Q14;
    assign w_qmag  = w_qneg ? (ONE_Q14 - r_level_near) : (r_level_near - ONE_Q14);
    assign w_lneg  = r_level_far < r_level_near;
    assign w_lmag  = w_lneg ? (r_level_near - r_level_far) : (r_level_far - r_level_near);
    assign w_lden  = r_knee_far - r_knee_near;
    assign w_lprod = w_lmag * (r_t - r_knee_near);
    assign w_qprod = r_k * r_tt;
    assign w_wv    = r_neg ? (18'(r_base) - 18'(w_q)) : (18'(r_base) + 18'(w_q));
    assign w_wprod = $signed({1'b0, r_w}) * r_box[r_j];
    assign w_amag  = r_acc[r_j][ACC_W-1] ? ACC_W'(-r_acc[r_j]) : ACC_W'(r_acc[r_j]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // raise on commit, drop once the sink takes the transaction
            if (w_we) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_cur[0] <= {i_box.box_x[15], i_box.box_x};
                        r_cur[1] <= {i_box.box_y[15], i_box.box_y};
                        r_cur[2] <= {1'b0, i_box.box_width};
                        r_cur[3] <= {1'b0, i_box.box_height};
                        for (int f = 0; f < 4; f++) begin
                            r_acc[f] <= '0;
                        end
                        r_wsum <= '0;
                        r_idx  <= '0;
                        r_j    <= '0;
                        if (r_fill != LAST_IDX) begin
                            r_res[0] <= i_box.box_x;
                            r_res[1] <= i_box.box_y;
                            r_res[2] <= i_box.box_width;
                            r_res[3] <= i_box.box_height;
                            r_smooth <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_CA;
                        end
                    end
                end
                S_CA: begin
                    r_acur  <= r_cur[2][15:0] * r_cur[3][15:0];
                    r_state <= S_D0SQ;
                end
                S_D0SQ: begin
                    r_d0sq  <= r_knee_near * r_knee_near;
                    r_state <= S_RD;
                end
                S_RD: begin
                    // the current box closes the window with a zero term
                    if (r_idx == LAST_IDX) begin
                        r_box   <= r_cur;
                        r_term  <= '0;
                        r_state <= S_T;
                    end else begin
                        r_state <= S_GEO;
                    end
                end
                S_GEO: begin
                    r_box   <= w_bf;
                    r_iw    <= w_iw;
                    r_ih    <= w_ih;
                    r_state <= S_OV;
                end
                S_OV: begin
                    r_ov    <= r_iw * r_ih;
                    r_state <= S_AB;
                end
                S_AB: begin
                    r_ab    <= r_box[2][15:0] * r_box[3][15:0];
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    if (w_min == '0) begin
                        r_term  <= 15'(ONE_Q14);
                        r_state <= S_T;
                    end else begin
                        r_num   <= {2'b00, r_ov, 14'd0};
                        r_den   <= w_min;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (w_div_done) begin
                        r_term  <= 15'(17'(ONE_Q14) - w_q);
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    r_t     <= w_tprod[29:14];
                    r_state <= S_CV;
                end
                S_CV: begin
                    if (r_t < r_knee_near) begin
                        r_tt    <= r_t * r_t;
                        r_base  <= ONE_Q14;
                        r_neg   <= w_qneg;
                        r_k     <= w_qmag;
                        r_state <= S_QNUM;
                    end else if (r_t < r_knee_far) begin
                        r_base  <= r_level_near;
                        r_neg   <= w_lneg;
                        r_num   <= 48'(w_lprod) + 48'(w_lden[15:1]);
                        r_den   <= 32'(w_lden);
                        r_state <= S_CDIV;
                    end else begin
                        r_w     <= r_level_far;
                        r_state <= S_ACC;
                    end
                end
                S_QNUM: begin
                    r_num   <= w_qprod + 48'(r_d0sq[31:1]);
                    r_den   <= r_d0sq;
                    r_state <= S_CDIV;
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (w_div_done) begin
                        r_w     <= w_wv[15:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    // one field per cycle
                    r_acc[r_j] <= r_acc[r_j] + ACC_W'(w_wprod);
                    if (r_j == 2'd0) begin
                        r_wsum <= r_wsum + WS_W'(r_w);
                    end
                    r_j <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (r_wsum == '0) begin
                        r_res[0] <= r_cur[0][15:0];
                        r_res[1] <= r_cur[1][15:0];
                        r_res[2] <= r_cur[2][15:0];
                        r_res[3] <= r_cur[3][15:0];
                        r_smooth <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_num   <= 48'(w_amag) + 48'(r_wsum[WS_W-1:1]);
                        r_den   <= 32'(r_wsum);
                        r_neg   <= r_acc[r_j][ACC_W-1];
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (w_div_done) begin
                        r_res[r_j] <= r_neg ? (~w_q[15:0] + 16'd1) : w_q[15:0];
                        r_j        <= r_j + 2'd1;
                        if (r_j == 2'd3) begin
                            r_smooth <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the output register frees up, then commit history
                    if (w_out_free) begin
                        r_out    <= r_res;
                        r_osm    <= r_smooth;
                        if (r_fill != LAST_IDX) begin
                            r_fill <= r_fill + 1'b1;
                        end else begin
                            r_head <= (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_box.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.out_x      = r_out[0];
    assign o_res.out_y      = r_out[1];
    assign o_res.out_width  = r_out[2];
    assign o_res.out_height = r_out[3];
    assign o_res.smoothed   = r_osm;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_TWAIT || r_state == S_CWAIT || r_state == S_FWAIT))
        else $error("divider finished outside a wait state");

    a_smooth_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.smoothed) |-> (r_fill == LAST_IDX))
        else $error("smoothed result before window filled");

    a_head_after_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != '0) |-> (r_fill == LAST_IDX))
        else $error("ring head moved while window filling");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (o_res.valid && r_state == S_IDLE))
        else $error("history commit without result");

endmodule

// File: rtl/owbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module owbs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 7,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/owbs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Caller guarantees the quotient fits in Q_W bits. Depends on owbs_pkg.
module owbs_div import owbs_pkg::*; #(
    parameter int DEN_W = DIV_DEN_W,
    parameter int Q_W   = DIV_Q_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DEN_W+Q_W-2:0] i_num,
    input  logic [DEN_W-1:0]     i_den,
    output logic                 o_done,
    output logic [Q_W-1:0]       o_quot
);

    localparam int NUM_W = DEN_W + Q_W - 1;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic             w_ge;

    assign w_ge   = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_dsh  <= {i_den, {(Q_W-1){1'b0}}};
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[Q_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
